// File: sv/sawt_pkg.sv
package sawt_pkg;

    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_SEND = 2'd1;
    localparam logic [1:0] FUNC_ACK  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_NOTHING = 3'd2;
    localparam logic [2:0] ST_LIMIT   = 3'd3;
    localparam logic [2:0] ST_STALE   = 3'd4;
    localparam logic [2:0] ST_FUTURE  = 3'd5;
    localparam logic [2:0] ST_BEYOND  = 3'd6;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_DONE   = 1'b1;

    // arg carries the segment count of a push or the sequence of an ack
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] id;
        logic [31:0] arg;
    } cmd_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [31:0] msg_num;
        logic [31:0] seq_start;
        logic [31:0] seq_count;
        logic [31:0] sent_seq;
        logic [31:0] done_id;
        logic [31:0] done_msg_num;
        logic [31:0] unacked_seq;
        logic [31:0] next_seq;
        logic        last;
    } res_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_DIV,
        F_PUT
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_SCAN_RD,
        B_SCAN_CHK,
        B_RETIRE
    } back_state_t;

endpackage

// File: sv/sawt_in_if.sv
interface sawt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] request_bytes;
    logic [31:0] request_id;
    logic [31:0] ack_seq;

    modport source (output valid, output func, output request_bytes, output request_id,
                    output ack_seq, input ready);
    modport sink (input valid, input func, input request_bytes, input request_id,
                  input ack_seq, output ready);
endinterface

// File: sv/sawt_out_if.sv
interface sawt_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [2:0]  status;
    logic [31:0] msg_num;
    logic [31:0] seq_start;
    logic [31:0] seq_count;
    logic [31:0] sent_seq;
    logic [31:0] done_id;
    logic [31:0] done_msg_num;
    logic [31:0] unacked_seq;
    logic [31:0] next_seq;
    logic        last;

    modport source (output valid, output kind, output status, output msg_num,
                    output seq_start, output seq_count, output sent_seq, output done_id,
                    output done_msg_num, output unacked_seq, output next_seq, output last,
                    input ready);
    modport sink (input valid, input kind, input status, input msg_num, input seq_start,
                  input seq_count, input sent_seq, input done_id, input done_msg_num,
                  input unacked_seq, input next_seq, input last, output ready);
endinterface

// File: sv/sawt_cmdq.sv
module sawt_cmdq
    import sawt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic empty
);

    cmd_t       ent_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = ent_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            ent_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (rd_en && !empty)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'((wr_en && !full) ? 1 : 0) - 2'((rd_en && !empty) ? 1 : 0);
        end
    end

endmodule

// File: sv/sawt_front.sv
module sawt_front
    import sawt_pkg::*;
#(
    parameter int SEGMENT_BYTES = 4096
)
(
    input  logic         clk,
    input  logic         rst_n,
    sawt_in_if.sink      in_ch,
    input  back_status_t bstat,
    output logic         q_wr,
    output cmd_t         q_data,
    input  logic         q_full
);

    // ceil(bytes / SEGMENT_BYTES) = floor((bytes + SEGMENT_BYTES - 1) * RCP >> SH),
    // RCP being the rounded-up reciprocal, exact for every 33-bit dividend
    localparam int SH = 33 + $clog2(SEGMENT_BYTES);
    localparam logic [63:0] RCP_L =
        ((64'd1 << SH) + 64'(SEGMENT_BYTES) - 64'd1) / 64'(SEGMENT_BYTES);
    localparam logic [33:0] RCP = RCP_L[33:0];

    front_state_t state_reg, state_next;
    cmd_t         cmd_reg;
    logic [32:0]  dvd_reg;
    logic [50:0]  plo_reg;
    logic [49:0]  phi_reg;
    logic [66:0]  prod;
    logic         take;

    assign in_ch.ready = (state_reg == F_IDLE) && !bstat.clearing;
    assign take        = in_ch.valid && in_ch.ready;
    assign prod        = 67'(plo_reg) + {phi_reg, 17'd0};
    assign q_data      = cmd_reg;

    always_comb
    begin
        state_next = state_reg;
        q_wr       = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (take)
                begin
                    if (in_ch.func == FUNC_PUSH)
                    begin
                        state_next = F_MUL;
                    end
                    else if (in_ch.func == FUNC_SEND || in_ch.func == FUNC_ACK)
                    begin
                        state_next = F_PUT;
                    end
                end
            end
            F_MUL:
            begin
                state_next = F_DIV;
            end
            F_DIV:
            begin
                state_next = F_PUT;
            end
            F_PUT:
            begin
                if (!q_full)
                begin
                    q_wr       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // partial products of the two dividend halves, then one add and a shift
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg.func <= in_ch.func;
            cmd_reg.id   <= in_ch.request_id;
            cmd_reg.arg  <= in_ch.ack_seq;
            dvd_reg      <= {1'b0, in_ch.request_bytes} + 33'(SEGMENT_BYTES - 1);
        end
        if (state_reg == F_MUL)
        begin
            plo_reg <= 51'(dvd_reg[16:0]) * 51'(RCP);
            phi_reg <= 50'(dvd_reg[32:17]) * 50'(RCP);
        end
        if (state_reg == F_DIV)
        begin
            cmd_reg.arg <= 32'(prod >> SH);
        end
    end

endmodule

// File: sv/sawt_back.sv
module sawt_back
    import sawt_pkg::*;
#(
    parameter int WINDOW_BITS = 2048,
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_data,
    input  cmd_t         q_data,
    input  logic         q_empty,
    output logic         q_rd,
    output back_status_t bstat,
    sawt_out_if.source   out_ch
);

    localparam int IW = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IW:0]   WLEN = (IW+1)'(WINDOW_BITS);
    localparam logic [FW:0]   QLEN = (FW+1)'(QUEUE_DEPTH);

    back_state_t   state_reg, state_next;
    logic [15:0]   inflight_reg;
    logic [31:0]   unacked_reg, unacked_next;
    logic [31:0]   snext_reg, snext_next;
    logic [31:0]   assigned_reg, assigned_next;
    logic [31:0]   msg_reg, msg_next;
    logic [IW-1:0] base_reg, base_next;
    logic [QW-1:0] head_reg, head_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [IW-1:0] clr_reg, clr_next;
    res_t          pend_reg, pend_next;
    res_t          out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic          bm_mem [WINDOW_BITS];
    logic          bm_rdata_reg;
    logic          bm_we;
    logic [IW-1:0] bm_waddr;
    logic          bm_wdata;

    logic [31:0]   id_mem  [QUEUE_DEPTH];
    logic [31:0]   msgq_mem [QUEUE_DEPTH];
    logic [32:0]   end_mem [QUEUE_DEPTH];
    logic          fq_we;
    logic [QW-1:0] tail;
    logic [FW:0]   tail_sum;
    logic [32:0]   new_end;

    logic          emit_ok;
    logic [31:0]   diff;
    logic [IW:0]   bit_sum;
    logic [IW-1:0] bit_addr;
    logic [IW:0]   base_inc;
    logic [QW:0]   head_inc;
    logic          retire;
    res_t          r;

    assign emit_ok  = !out_valid_reg || out_ch.ready;
    assign bstat.clearing = (state_reg == B_CLEAR);
    assign tail_sum = (FW+1)'(head_reg) + (FW+1)'(fill_reg);
    assign tail     = (tail_sum >= QLEN) ? QW'(tail_sum - QLEN) : QW'(tail_sum);
    assign new_end  = {1'b0, assigned_reg} + {1'b0, q_data.arg};
    assign diff     = q_data.arg - unacked_reg;
    assign bit_sum  = (IW+1)'(base_reg) + (IW+1)'(diff[IW-1:0]);
    assign bit_addr = (bit_sum >= WLEN) ? IW'(bit_sum - WLEN) : IW'(bit_sum);
    assign base_inc = (IW+1)'(base_reg) + (IW+1)'(1);
    assign head_inc = (QW+1)'(head_reg) + (QW+1)'(1);
    assign retire   = (fill_reg != '0) && (end_mem[head_reg] <= {1'b0, unacked_reg});

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.kind         = out_reg.kind;
    assign out_ch.status       = out_reg.status;
    assign out_ch.msg_num      = out_reg.msg_num;
    assign out_ch.seq_start    = out_reg.seq_start;
    assign out_ch.seq_count    = out_reg.seq_count;
    assign out_ch.sent_seq     = out_reg.sent_seq;
    assign out_ch.done_id      = out_reg.done_id;
    assign out_ch.done_msg_num = out_reg.done_msg_num;
    assign out_ch.unacked_seq  = out_reg.unacked_seq;
    assign out_ch.next_seq     = out_reg.next_seq;
    assign out_ch.last         = out_reg.last;

    always_comb
    begin
        state_next     = state_reg;
        unacked_next   = unacked_reg;
        snext_next     = snext_reg;
        assigned_next  = assigned_reg;
        msg_next       = msg_reg;
        base_next      = base_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        clr_next       = clr_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        q_rd           = 1'b0;
        bm_we          = 1'b0;
        bm_waddr       = base_reg;
        bm_wdata       = 1'b0;
        fq_we          = 1'b0;
        r              = '0;
        r.kind         = KIND_STATUS;
        r.status       = ST_OK;
        r.unacked_seq  = unacked_reg;
        r.next_seq     = snext_reg;
        r.last         = 1'b1;
        case (state_reg)
            B_CLEAR:
            begin
                bm_we    = 1'b1;
                bm_waddr = clr_reg;
                clr_next = clr_reg + IW'(1);
                if ((IW+1)'(clr_reg) == WLEN - (IW+1)'(1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty && emit_ok)
                begin
                    q_rd = 1'b1;
                    out_valid_next = 1'b1;
                    if (q_data.func == FUNC_PUSH)
                    begin
                        if ((FW+1)'(fill_reg) >= QLEN)
                        begin
                            r.status = ST_FULL;
                        end
                        else
                        begin
                            fq_we         = 1'b1;
                            fill_next     = fill_reg + FW'(1);
                            msg_next      = msg_reg + 32'd1;
                            assigned_next = new_end[31:0];
                            r.msg_num     = msg_reg;
                            r.seq_start   = assigned_reg;
                            r.seq_count   = q_data.arg;
                        end
                    end
                    else if (q_data.func == FUNC_SEND)
                    begin
                        if (snext_reg - unacked_reg >= {16'd0, inflight_reg})
                        begin
                            r.status = ST_LIMIT;
                        end
                        else if (snext_reg >= assigned_reg)
                        begin
                            r.status = ST_NOTHING;
                        end
                        else
                        begin
                            snext_next = snext_reg + 32'd1;
                            r.sent_seq = snext_reg;
                            r.next_seq = snext_reg + 32'd1;
                        end
                    end
                    else
                    begin
                        if (q_data.arg < unacked_reg)
                        begin
                            r.status = ST_STALE;
                        end
                        else if (q_data.arg >= snext_reg)
                        begin
                            r.status = ST_FUTURE;
                        end
                        else if (diff >= 32'(WINDOW_BITS))
                        begin
                            r.status = ST_BEYOND;
                        end
                        else if (diff != 32'd0)
                        begin
                            bm_we    = 1'b1;
                            bm_waddr = bit_addr;
                            bm_wdata = 1'b1;
                        end
                        else
                        begin
                            // the oldest segment itself: its bit is known clear, just step over it
                            out_valid_next = out_valid_reg && !out_ch.ready;
                            pend_next      = r;
                            unacked_next   = unacked_reg + 32'd1;
                            base_next      = (base_inc >= WLEN) ? '0 : IW'(base_inc);
                            state_next     = (unacked_reg + 32'd1 < snext_reg) ?
                                             B_SCAN_RD : B_RETIRE;
                        end
                    end
                    out_next = r;
                end
            end
            B_SCAN_RD:
            begin
                state_next = B_SCAN_CHK;
            end
            B_SCAN_CHK:
            begin
                if (bm_rdata_reg)
                begin
                    bm_we        = 1'b1;
                    unacked_next = unacked_reg + 32'd1;
                    base_next    = (base_inc >= WLEN) ? '0 : IW'(base_inc);
                    state_next   = (unacked_reg + 32'd1 < snext_reg) ? B_SCAN_RD : B_RETIRE;
                end
                else
                begin
                    state_next = B_RETIRE;
                end
            end
            B_RETIRE:
            begin
                // pending result leaves once it is known whether another follows
                if (emit_ok)
                begin
                    out_valid_next       = 1'b1;
                    out_next             = pend_reg;
                    out_next.unacked_seq = unacked_reg;
                    out_next.next_seq    = snext_reg;
                    out_next.last        = !retire;
                    if (retire)
                    begin
                        pend_next              = r;
                        pend_next.kind         = KIND_DONE;
                        pend_next.done_id      = id_mem[head_reg];
                        pend_next.done_msg_num = msgq_mem[head_reg];
                        head_next = (head_inc >= (QW+1)'(QUEUE_DEPTH)) ? '0 : QW'(head_inc);
                        fill_next = fill_reg - FW'(1);
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        bm_rdata_reg <= bm_mem[base_reg];
    end

    always_ff @(posedge clk)
    begin
        if (fq_we)
        begin
            id_mem[tail]   <= q_data.id;
            msgq_mem[tail] <= msg_reg;
            end_mem[tail]  <= new_end;
        end
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            inflight_reg  <= 16'd10000;
            unacked_reg   <= '0;
            snext_reg     <= '0;
            assigned_reg  <= '0;
            msg_reg       <= '0;
            base_reg      <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                inflight_reg <= cfg_data;
            end
            unacked_reg   <= unacked_next;
            snext_reg     <= snext_next;
            assigned_reg  <= assigned_next;
            msg_reg       <= msg_next;
            base_reg      <= base_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/segment_ack_window_tracker.sv
// Send and ack items pass the front command register, the command queue and the back output
// register; a push also passes F_MUL and F_DIV (segment count by a reciprocal multiply).
// The front takes no new item until the last is in the queue. An ack of the oldest segment
// walks the bitmap via B_SCAN_RD and B_SCAN_CHK per further segment, then 1 result a cycle
// while retiring and the output is not stalled. Reset is asynchronous, active low; then the
// bitmap memory is cleared one bit a cycle, during which no item is taken.
module segment_ack_window_tracker
    import sawt_pkg::*;
#(
    parameter int WINDOW_BITS   = 2048,
    parameter int SEGMENT_BYTES = 4096,
    parameter int QUEUE_DEPTH   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    sawt_in_if.sink     in_ch,
    sawt_out_if.source  out_ch
);

    back_status_t bstat;
    logic         q_wr;
    cmd_t         q_wdata;
    logic         q_full;
    logic         q_rd;
    cmd_t         q_rdata;
    logic         q_empty;

    sawt_front #(
        .SEGMENT_BYTES(SEGMENT_BYTES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .bstat  (bstat),
        .q_wr   (q_wr),
        .q_data (q_wdata),
        .q_full (q_full)
    );

    sawt_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    sawt_back #(
        .WINDOW_BITS(WINDOW_BITS),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .q_data   (q_rdata),
        .q_empty  (q_empty),
        .q_rd     (q_rd),
        .bstat    (bstat),
        .out_ch   (out_ch)
    );

endmodule
